### rtl/mid_side_biquad_crossfeed_unit_macros.svh
// Assertion macros for the mid/side crossfeed unit checker.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef MID_SIDE_BIQUAD_CROSSFEED_UNIT_MACROS_SVH
`define MID_SIDE_BIQUAD_CROSSFEED_UNIT_MACROS_SVH

`define MSBC_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define MSBC_ASSERT(lbl, prop, msg) \
  `MSBC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

### rtl/msbc_pkg.sv
// Shared types, constants and saturation helper for the crossfeed unit.
// No dependencies; imported by regs, ctrl, dp and top; the checker names it by scope.
package msbc_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEF_FRAC_DEF   = 30;
  localparam int ST_W            = 48;
  localparam int WIDE_W          = 84;
  localparam int OUT_FRAC        = 31;
  localparam int PADDR_W         = 5;
  localparam int CFG_DW          = 32;

  localparam logic [15:0] IN_LVL_RST  = 16'd29491;
  localparam logic [15:0] OUT_LVL_RST = 16'd32768;
  localparam logic [31:0] B0_RST      = 32'h4000_0000;

  localparam logic signed [ST_W-1:0] ST_MAX = $signed({1'b0, {(ST_W-1){1'b1}}});
  localparam logic signed [ST_W-1:0] ST_MIN = ~ST_MAX;
  localparam logic signed [WIDE_W-1:0] WIDE_ST_MAX =
    $signed({{(WIDE_W-ST_W+1){1'b0}}, {(ST_W-1){1'b1}}});
  localparam logic signed [WIDE_W-1:0] WIDE_ST_MIN = ~WIDE_ST_MAX;

  typedef struct packed {
    logic [15:0] in_lvl;
    logic [15:0] out_lvl;
    logic [31:0] b0;
    logic [31:0] b1;
    logic [31:0] b2;
    logic [31:0] fb1;
    logic [31:0] fb2;
  } cfg_t;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_MS, MUL_B0, MUL_B1, MUL_B2, MUL_FB1, MUL_FB2, MUL_SUM, MUL_DIFF
  } mul_op_e;

  typedef enum logic [3:0] {
    ACC_NONE, ACC_MS, ACC_B0, ACC_B1, ACC_FB1, ACC_B2, ACC_FB2, ACC_L, ACC_R
  } acc_op_e;

  typedef struct packed {
    logic    load;
    mul_op_e mul;
    acc_op_e acc;
  } cmd_t;

  function automatic logic signed [ST_W-1:0] sat_st(input logic signed [WIDE_W-1:0] v);
    logic signed [ST_W-1:0] r;
    if (v > WIDE_ST_MAX) begin
      r = ST_MAX;
    end else if (v < WIDE_ST_MIN) begin
      r = ST_MIN;
    end else begin
      r = $signed(v[ST_W-1:0]);
    end
    return r;
  endfunction

endpackage

### rtl/msbc_regs.sv
// APB-style configuration registers: levels and biquad coefficients.
// Depends on msbc_pkg.
module msbc_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [msbc_pkg::PADDR_W-1:0]  paddr,
  input  logic [msbc_pkg::CFG_DW-1:0]   pwdata,
  output logic [msbc_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  output msbc_pkg::cfg_t                cfg_o
);
  import msbc_pkg::*;

  typedef enum logic [PADDR_W-3:0] {
    REG_IN_LVL, REG_OUT_LVL, REG_B0, REG_B1, REG_B2, REG_FB1, REG_FB2
  } reg_idx_e;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.in_lvl  <= IN_LVL_RST;
      cfg_q.out_lvl <= OUT_LVL_RST;
      cfg_q.b0      <= B0_RST;
      cfg_q.b1      <= '0;
      cfg_q.b2      <= '0;
      cfg_q.fb1     <= '0;
      cfg_q.fb2     <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_IN_LVL:  cfg_q.in_lvl  <= pwdata[15:0];
        REG_OUT_LVL: cfg_q.out_lvl <= pwdata[15:0];
        REG_B0:      cfg_q.b0      <= pwdata;
        REG_B1:      cfg_q.b1      <= pwdata;
        REG_B2:      cfg_q.b2      <= pwdata;
        REG_FB1:     cfg_q.fb1     <= pwdata;
        REG_FB2:     cfg_q.fb2     <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_IN_LVL:  prdata = {{(CFG_DW-16){1'b0}}, cfg_q.in_lvl};
      REG_OUT_LVL: prdata = {{(CFG_DW-16){1'b0}}, cfg_q.out_lvl};
      REG_B0:      prdata = cfg_q.b0;
      REG_B1:      prdata = cfg_q.b1;
      REG_B2:      prdata = cfg_q.b2;
      REG_FB1:     prdata = cfg_q.fb1;
      REG_FB2:     prdata = cfg_q.fb2;
      default:     prdata = '0;
    endcase
  end

endmodule

### rtl/msbc_ctrl.sv
// Sequencer: steps the shared multiplier pair through one sample pair
// and owns both handshakes. Depends on msbc_pkg.
module msbc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output msbc_pkg::cmd_t cmd_o
);
  import msbc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MS, ST_MSW, ST_B0, ST_B1, ST_FB1, ST_B2, ST_FB2, ST_OL, ST_OR, ST_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   fin_go;
  logic   accept;

  assign fin_go      = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);
  assign in_ready_o  = (state_q == ST_IDLE) || fin_go;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d      = state_q;
    cmd_o.load   = accept;
    cmd_o.mul    = MUL_NONE;
    cmd_o.acc    = ACC_NONE;
    out_valid_d  = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_MS;
        end
      end
      ST_MS: begin
        cmd_o.mul = MUL_MS;
        state_d   = ST_MSW;
      end
      ST_MSW: begin
        cmd_o.acc = ACC_MS;
        state_d   = ST_B0;
      end
      ST_B0: begin
        cmd_o.mul = MUL_B0;
        state_d   = ST_B1;
      end
      ST_B1: begin
        cmd_o.mul = MUL_B1;
        cmd_o.acc = ACC_B0;
        state_d   = ST_FB1;
      end
      ST_FB1: begin
        cmd_o.mul = MUL_FB1;
        cmd_o.acc = ACC_B1;
        state_d   = ST_B2;
      end
      ST_B2: begin
        cmd_o.mul = MUL_B2;
        cmd_o.acc = ACC_FB1;
        state_d   = ST_FB2;
      end
      ST_FB2: begin
        cmd_o.mul = MUL_FB2;
        cmd_o.acc = ACC_B2;
        state_d   = ST_OL;
      end
      ST_OL: begin
        cmd_o.mul = MUL_SUM;
        cmd_o.acc = ACC_FB2;
        state_d   = ST_OR;
      end
      ST_OR: begin
        cmd_o.mul = MUL_DIFF;
        cmd_o.acc = ACC_L;
        state_d   = ST_FIN;
      end
      ST_FIN: begin
        if (fin_go) begin
          cmd_o.acc   = ACC_R;
          out_valid_d = 1'b1;
          state_d     = accept ? ST_MS : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### rtl/msbc_dp.sv
// Datapath: mid/side split, biquad on side, output mix, with one
// 34x33 and one 17x33 multiplier shared across steps. Depends on msbc_pkg.
module msbc_dp #(
  parameter int SAMPLE_BITS    = msbc_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = msbc_pkg::COEF_FRAC_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  msbc_pkg::cmd_t                cmd_i,
  input  msbc_pkg::cfg_t                cfg_i,
  input  logic signed [SAMPLE_BITS-1:0] left_in_i,
  input  logic signed [SAMPLE_BITS-1:0] right_in_i,
  input  logic                          bypass_i,
  output logic signed [SAMPLE_BITS-1:0] left_out_o,
  output logic signed [SAMPLE_BITS-1:0] right_out_o
);
  import msbc_pkg::*;

  localparam int SW    = SAMPLE_BITS;
  localparam int AH_W  = 34;
  localparam int BH_W  = 33;
  localparam int AL_W  = 17;
  localparam int PH_W  = AH_W + BH_W;
  localparam int PL_W  = AL_W + BH_W;
  localparam int MR_W  = ST_W + 2;
  localparam int SUM_W = ST_W + 1;

  localparam logic signed [WIDE_W-1:0] HALF_C =
    $signed({{(WIDE_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1));
  localparam logic signed [WIDE_W-1:0] HALF_O =
    $signed({{(WIDE_W-1){1'b0}}, 1'b1} << (OUT_FRAC - 1));
  localparam logic signed [WIDE_W-1:0] WIDE_MR_MAX =
    $signed({{(WIDE_W-ST_W-1){1'b0}}, 1'b1, {ST_W{1'b0}}});
  localparam logic signed [WIDE_W-1:0] WIDE_MR_MIN = -WIDE_MR_MAX;
  localparam logic signed [MR_W-1:0] MR_MAX = $signed({2'b01, {ST_W{1'b0}}});
  localparam logic signed [MR_W-1:0] MR_MIN = -MR_MAX;
  localparam logic signed [MR_W-1:0] SMP_MAX =
    $signed({{(MR_W-SW+1){1'b0}}, {(SW-1){1'b1}}});
  localparam logic signed [MR_W-1:0] SMP_MIN = ~SMP_MAX;

  logic signed [SW-1:0]    l_q, r_q, lt_q, lout_q, rout_q;
  logic                    byp_q;
  logic signed [ST_W-1:0]  mid_q, side_q, os_q, s1_q, s2_q;
  logic signed [MR_W-1:0]  t1_q, t2_q;
  logic signed [PH_W-1:0]  ph_q;
  logic signed [PL_W-1:0]  pl_q;

  logic signed [SW:0]      lsum, ldif;
  logic signed [SUM_W-1:0] a_sel;
  logic signed [BH_W-1:0]  b_sel, b_hi, b_lo;
  logic signed [AH_W-1:0]  a_hi;
  logic signed [AL_W-1:0]  a_lo;
  logic                    out_mode;
  logic signed [WIDE_W-1:0] wide_x, wide_sh;
  logic signed [MR_W-1:0]  m;
  logic signed [SW-1:0]    smp;

  assign lsum = $signed({l_q[SW-1], l_q}) + $signed({r_q[SW-1], r_q});
  assign ldif = $signed({l_q[SW-1], l_q}) - $signed({r_q[SW-1], r_q});

  always_comb begin
    case (cmd_i.mul)
      MUL_B0, MUL_B1, MUL_B2: a_sel = SUM_W'(side_q);
      MUL_FB1, MUL_FB2:       a_sel = SUM_W'(os_q);
      MUL_SUM:                a_sel = SUM_W'(mid_q) + SUM_W'(os_q);
      MUL_DIFF:               a_sel = SUM_W'(mid_q) - SUM_W'(os_q);
      default:                a_sel = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.mul)
      MUL_B0:            b_sel = BH_W'($signed(cfg_i.b0));
      MUL_B1:            b_sel = BH_W'($signed(cfg_i.b1));
      MUL_B2:            b_sel = BH_W'($signed(cfg_i.b2));
      MUL_FB1:           b_sel = BH_W'($signed(cfg_i.fb1));
      MUL_FB2:           b_sel = BH_W'($signed(cfg_i.fb2));
      MUL_SUM, MUL_DIFF: b_sel = $signed({{(BH_W-16){1'b0}}, cfg_i.out_lvl});
      default:           b_sel = '0;
    endcase
  end

  always_comb begin
    if (cmd_i.mul == MUL_MS) begin
      a_hi = AH_W'(lsum);
      b_hi = $signed({{(BH_W-16){1'b0}}, cfg_i.in_lvl});
      a_lo = $signed({1'b0, cfg_i.in_lvl});
      b_lo = BH_W'(ldif);
    end else begin
      a_hi = AH_W'($signed(a_sel[SUM_W-1:16]));
      b_hi = b_sel;
      a_lo = $signed({1'b0, a_sel[15:0]});
      b_lo = b_sel;
    end
  end

  assign out_mode = (cmd_i.acc == ACC_L) || (cmd_i.acc == ACC_R);
  assign wide_x   = (WIDE_W'(ph_q) <<< 16) + WIDE_W'(pl_q) + (out_mode ? HALF_O : HALF_C);
  assign wide_sh  = out_mode ? (wide_x >>> OUT_FRAC) : (wide_x >>> COEF_FRAC_BITS);

  always_comb begin
    if (wide_sh > WIDE_MR_MAX) begin
      m = MR_MAX;
    end else if (wide_sh < WIDE_MR_MIN) begin
      m = MR_MIN;
    end else begin
      m = $signed(wide_sh[MR_W-1:0]);
    end
  end

  always_comb begin
    if (m > SMP_MAX) begin
      smp = SMP_MAX[SW-1:0];
    end else if (m < SMP_MIN) begin
      smp = SMP_MIN[SW-1:0];
    end else begin
      smp = $signed(m[SW-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else begin
      case (cmd_i.acc)
        ACC_FB1: s1_q <= sat_st(WIDE_W'(t1_q) + WIDE_W'(s2_q) + WIDE_W'(m));
        ACC_FB2: s2_q <= sat_st(WIDE_W'(t2_q) + WIDE_W'(m));
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      l_q   <= left_in_i;
      r_q   <= right_in_i;
      byp_q <= bypass_i;
    end
    if (cmd_i.mul != MUL_NONE) begin
      ph_q <= a_hi * b_hi;
      pl_q <= a_lo * b_lo;
    end
    case (cmd_i.acc)
      ACC_MS: begin
        mid_q  <= sat_st(WIDE_W'(ph_q));
        side_q <= sat_st(WIDE_W'(pl_q));
      end
      ACC_B0: os_q <= sat_st(WIDE_W'(m) + WIDE_W'(s1_q));
      ACC_B1: t1_q <= m;
      ACC_B2: t2_q <= m;
      ACC_L:  lt_q <= smp;
      ACC_R: begin
        lout_q <= byp_q ? l_q : lt_q;
        rout_q <= byp_q ? r_q : smp;
      end
      default: begin
      end
    endcase
  end

  assign left_out_o  = lout_q;
  assign right_out_o = rout_q;

endmodule

### rtl/mid_side_biquad_crossfeed_unit.sv
// Mid/side headphone crossfeed with a loadable biquad on the side signal.
// Each input pair passes through the mid/side split and its write-back,
// seven rounding multiplies on one shared multiplier pair and the output
// step; a new pair is taken only when idle or during that output step.
// An unread result stalls the last step only.
// Reset clears control, filter state and loads the register defaults.
module mid_side_biquad_crossfeed_unit #(
  parameter int SAMPLE_BITS    = msbc_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = msbc_pkg::COEF_FRAC_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] left_in_i,
  input  logic signed [SAMPLE_BITS-1:0] right_in_i,
  input  logic                          bypass_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] left_out_o,
  output logic signed [SAMPLE_BITS-1:0] right_out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [msbc_pkg::PADDR_W-1:0]  paddr,
  input  logic [msbc_pkg::CFG_DW-1:0]   pwdata,
  output logic [msbc_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);
  import msbc_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  msbc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  msbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  msbc_dp #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_i       (cfg),
    .left_in_i   (left_in_i),
    .right_in_i  (right_in_i),
    .bypass_i    (bypass_i),
    .left_out_o  (left_out_o),
    .right_out_o (right_out_o)
  );

endmodule

### rtl/msbc_chk.sv
// Port-level checker for the crossfeed unit, bound to the top level.
// Depends on mid_side_biquad_crossfeed_unit_macros.svh.
`include "mid_side_biquad_crossfeed_unit_macros.svh"

module msbc_chk #(
  parameter int SAMPLE_BITS = msbc_pkg::SAMPLE_BITS_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [SAMPLE_BITS-1:0] left_out_o,
  input logic [SAMPLE_BITS-1:0] right_out_o
);

  `MSBC_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(left_out_o) && $stable(right_out_o), "output dropped or changed while stalled")
  `MSBC_ASSERT(a_busy, in_valid_i && in_ready_o |-> ##9 !in_ready_o, "input taken while busy")
  `MSBC_ASSERT(a_rise_busy, $rose(out_valid_o) |-> $past(!in_ready_o, 2), "result without work")

endmodule

bind mid_side_biquad_crossfeed_unit msbc_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_chk (.*);
